[hw/rtl/dke_pkg.sv]
// shared types, constants and helper functions for the der key encoder
package dke_pkg;

   localparam int BUFFER_BYTES_DEF = 4096;
   // width of encoding positions and lengths, covers the largest store size
   localparam int POS_W = 16;
   localparam int NUM_COMP = 8;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_PENDING = 2'd1;
   localparam logic [1:0] STAT_ERROR   = 2'd2;

   localparam logic [7:0] TAG_INTEGER  = 8'h02;
   localparam logic [7:0] TAG_OCTETS   = 8'h04;
   localparam logic [7:0] TAG_SEQUENCE = 8'h30;

   localparam logic [0:0] FUNC_LOAD = 1'b0;
   localparam logic [0:0] FUNC_PULL = 1'b1;

   localparam logic [0:0] CSR_PKCS1_MODE  = 1'b0;
   localparam logic [0:0] CSR_KEY_VERSION = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_TOT,
      ST_WALK,
      ST_READ,
      ST_DONE
   } st_type;

   // pieces of the encoding, in output order
   typedef enum logic [2:0] {
      SG_OUTER_HDR,
      SG_VER0,
      SG_ALG,
      SG_OCT_HDR,
      SG_SEQ_HDR,
      SG_VER,
      SG_INT_HDR,
      SG_INT_BODY
   } seg_type;

   typedef struct packed {
      logic load;
      logic start;
      logic sum;
      logic tot;
      logic walk;
      logic capture;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic sum_done;
      logic tot_done;
      logic hit;
      logic mem;
      logic out_free;
   } sts_type;

   // tag plus length octets
   function automatic logic [2:0] hdr_size(input logic [POS_W-1:0] len);
      logic [2:0] s;
      if (len <= POS_W'(127)) s = 3'd2;
      else if (len <= POS_W'(255)) s = 3'd3;
      else s = 3'd4;
      return s;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [7:0] tag,
                                           input logic [POS_W-1:0] len,
                                           input logic [POS_W-1:0] k);
      logic [7:0] b;
      logic two;
      two = (len > POS_W'(255));
      if (k == '0) b = tag;
      else if (len <= POS_W'(127)) b = len[7:0];
      else if (k == POS_W'(1)) b = two ? 8'h82 : 8'h81;
      else if (k == POS_W'(2) && two) b = len[15:8];
      else b = len[7:0];
      return b;
   endfunction

   // rsaEncryption algorithm identifier with null parameters
   function automatic logic [7:0] alg_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0: b = 8'h30;
         4'd1: b = 8'h0D;
         4'd2: b = 8'h06;
         4'd3: b = 8'h09;
         4'd4: b = 8'h2A;
         4'd5: b = 8'h86;
         4'd6: b = 8'h48;
         4'd7: b = 8'h86;
         4'd8: b = 8'hF7;
         4'd9: b = 8'h0D;
         4'd10: b = 8'h01;
         4'd11: b = 8'h01;
         4'd12: b = 8'h01;
         4'd13: b = 8'h05;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[hw/rtl/der_rsa_private_key_encoder_unit.sv]
// top level of the der rsa private key encoder
//
// Requests arrive on the req_ stream. tuser is the function: a load brings
// one big-endian magnitude byte of a key integer (modulus, e, d, p, q, dP,
// dQ, qInv in that order, tlast on each integer's final byte); a pull asks
// for the next octet of the DER encoding. Loads give no response; each pull
// gives one response on the rsp_ stream: the octet in tdata, tlast on the
// final octet of the encoding, and the status in tuser (ok, keys pending,
// order or overflow error). The csr_ port selects PKCS#1 or PKCS#8 output
// and sets the version integer.
// A load is taken in the idle state, and the block stays idle. A pull's
// response is built in steps: the eight integer lengths are summed, the
// wrapper lengths are derived, the encoding is walked piece by piece, a key
// store read follows for an integer body octet, and the octet is loaded
// into the output register. A pull before all keys are loaded or after an
// error skips to that last step. The next request is taken the cycle after
// the response is loaded. Reset clears the lengths, position, error and
// configuration; the store itself needs no clearing. One response is held
// in an output register; while the receiver stalls, further loads are still
// taken and a new pull waits for the register to free before it completes.
module der_rsa_private_key_encoder_unit #(
   parameter int BUFFER_BYTES = dke_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // component [2:0], value_byte [10:3], zero fill
   input  logic        req_tuser,   // func
   input  logic        req_tlast,   // byte_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic [1:0]  rsp_tuser,   // status [1:0]
   output logic        rsp_tlast,   // out_last
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import dke_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dke_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   dke_dpath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_component  (req_tdata[2:0]),
      .req_value_byte (req_tdata[10:3]),
      .req_byte_last  (req_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_out_byte   (rsp_tdata),
      .rsp_out_last   (rsp_tlast),
      .rsp_status     (rsp_tuser)
   );

   // final octet only on a good response
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == STAT_OK)
      else $error("last flag on a failed response");

   // failed responses carry a zero octet
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata == 8'h00)
      else $error("nonzero octet on a failed response");

   // a pull blocks further requests while it is worked on
   a_pull_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == FUNC_PULL |=> !req_tready)
      else $error("request taken during a pull");

   // a response appears only after a pull was taken
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without a pull");
endmodule

[hw/rtl/dke_ram.sv]
// generic single-port-write ram with registered read
module dke_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/dke_ctrl.sv]
// controller state machine sequencing loads and pulls
module dke_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_func,
   input  dke_pkg::sts_type sts,
   output logic             req_tready,
   output dke_pkg::cmd_type cmd
);
   import dke_pkg::*;

   st_type state_ff, state_in;
   logic   accept;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_LOAD) begin
               cmd.load = 1'b1;
            end
            if (accept && req_func == FUNC_PULL) begin
               cmd.start = 1'b1;
               state_in  = sts.bad ? ST_DONE : ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (sts.sum_done) state_in = ST_TOT;
         end
         ST_TOT: begin
            cmd.tot = 1'b1;
            if (sts.tot_done) state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.hit) state_in = sts.mem ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            cmd.capture = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[hw/rtl/dke_dpath.sv]
// datapath: key store, length bookkeeping, encoding walk and output register
module dke_dpath #(
   parameter int BUFFER_BYTES = dke_pkg::BUFFER_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  dke_pkg::cmd_type cmd,
   output dke_pkg::sts_type sts,
   input  logic [2:0]       req_component,
   input  logic [7:0]       req_value_byte,
   input  logic             req_byte_last,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   output logic [1:0]       rsp_status
);
   import dke_pkg::*;

   localparam int LW = $clog2(BUFFER_BYTES + 1);
   localparam int AW = $clog2(BUFFER_BYTES);

   // configuration
   logic       mode_ff;
   logic [7:0] version_ff;

   // load bookkeeping
   logic [LW-1:0] len_ff [NUM_COMP];
   logic          pad_ff [NUM_COMP];
   logic [3:0]    next_ff;
   logic [LW-1:0] fill_ff;
   logic          seen_ff;
   logic          err_ff;

   // pull bookkeeping
   logic [POS_W-1:0] pos_ff, dsum_ff, stlv_ff, main_ff, total_ff, r_ff, off_ff;
   logic [2:0]       ci_ff;
   logic [1:0]       tcnt_ff;
   seg_type          seg_ff;
   logic [7:0]       res_byte_ff;
   logic [1:0]       res_status_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic [1:0] rsp_status_ff;

   logic [2:0]       idx;
   logic [POS_W-1:0] il, vt, seglen;
   logic [7:0]       seg_byte;
   logic             hit, mem_rd;
   logic             comp_ok, store_byte, full, store_ok;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       ram_q;
   logic             pos_end;

   // one shared index into the per-component registers
   assign idx = cmd.load ? next_ff[2:0] : ci_ff;
   assign il  = POS_W'(len_ff[idx]) + POS_W'(pad_ff[idx]);
   assign vt  = version_ff[7] ? POS_W'(4) : POS_W'(3);

   // load decisions
   assign comp_ok    = (next_ff < 4'd8) && (req_component == next_ff[2:0]);
   assign store_byte = seen_ff || (req_value_byte != 8'h00);
   assign full       = (fill_ff >= LW'(BUFFER_BYTES));
   assign store_ok   = cmd.load && comp_ok && store_byte && !full;

   // length and byte of the current piece of the encoding
   always_comb begin
      seglen   = '0;
      seg_byte = 8'h00;
      case (seg_ff)
         SG_OUTER_HDR: begin
            seglen   = POS_W'(hdr_size(main_ff));
            seg_byte = hdr_byte(TAG_SEQUENCE, main_ff, r_ff);
         end
         SG_VER0: begin
            seglen   = POS_W'(3);
            seg_byte = (r_ff == '0) ? TAG_INTEGER : (r_ff == POS_W'(1)) ? 8'h01 : 8'h00;
         end
         SG_ALG: begin
            seglen   = POS_W'(15);
            seg_byte = alg_byte(r_ff[3:0]);
         end
         SG_OCT_HDR: begin
            seglen   = POS_W'(hdr_size(stlv_ff));
            seg_byte = hdr_byte(TAG_OCTETS, stlv_ff, r_ff);
         end
         SG_SEQ_HDR: begin
            seglen   = POS_W'(hdr_size(dsum_ff));
            seg_byte = hdr_byte(TAG_SEQUENCE, dsum_ff, r_ff);
         end
         SG_VER: begin
            seglen = vt;
            if (r_ff == '0) seg_byte = TAG_INTEGER;
            else if (r_ff == POS_W'(1)) seg_byte = vt[7:0] - 8'd2;
            else if (r_ff == vt - POS_W'(1)) seg_byte = version_ff;
            else seg_byte = 8'h00;
         end
         SG_INT_HDR: begin
            seglen   = POS_W'(hdr_size(il));
            seg_byte = hdr_byte(TAG_INTEGER, il, r_ff);
         end
         SG_INT_BODY: begin
            seglen   = il;
            seg_byte = 8'h00;
         end
         default: seglen = '0;
      endcase
   end

   assign hit     = (r_ff < seglen);
   assign mem_rd  = (seg_ff == SG_INT_BODY) && !(pad_ff[idx] && r_ff == '0);
   assign rd_addr = AW'(off_ff + r_ff - POS_W'(pad_ff[idx]));
   assign pos_end = (pos_ff + POS_W'(1) == total_ff);

   // byte store
   dke_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (store_ok),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_value_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         version_ff <= 8'h00;
      end else if (csr_we) begin
         if (csr_index == CSR_PKCS1_MODE) mode_ff <= csr_wdata[0];
         if (csr_index == CSR_KEY_VERSION) version_ff <= csr_wdata;
      end
   end

   // load bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COMP; i++) begin
            len_ff[i] <= '0;
            pad_ff[i] <= 1'b0;
         end
         next_ff <= '0;
         fill_ff <= '0;
         seen_ff <= 1'b0;
         err_ff  <= 1'b0;
      end else if (cmd.load) begin
         if (!comp_ok || (store_byte && full)) begin
            err_ff <= 1'b1;
         end else begin
            if (store_ok) begin
               if (!seen_ff) pad_ff[idx] <= req_value_byte[7];
               fill_ff     <= fill_ff + LW'(1);
               len_ff[idx] <= len_ff[idx] + LW'(1);
            end
            // magnitude has started until the component's last byte
            seen_ff <= (seen_ff || store_ok) && !req_byte_last;
            if (req_byte_last) begin
               if (len_ff[idx] == '0 && !store_ok) pad_ff[idx] <= 1'b1;
               next_ff <= next_ff + 4'd1;
            end
         end
      end
   end

   // emit position
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.tot && tcnt_ff == 2'd3 && pos_ff >= total_ff) begin
         pos_ff <= '0;
      end else if (cmd.emit && res_status_ff == STAT_OK) begin
         pos_ff <= pos_end ? '0 : pos_ff + POS_W'(1);
      end
   end

   // length sums and the walk over the encoding
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dsum_ff       <= vt;
         ci_ff         <= '0;
         tcnt_ff       <= '0;
         res_byte_ff   <= 8'h00;
         res_status_ff <= err_ff ? STAT_ERROR :
                          (next_ff < 4'd8) ? STAT_PENDING : STAT_OK;
      end
      if (cmd.sum) begin
         dsum_ff <= dsum_ff + POS_W'(hdr_size(il)) + il;
         ci_ff   <= ci_ff + 3'd1;
      end
      if (cmd.tot) begin
         tcnt_ff <= tcnt_ff + 2'd1;
         case (tcnt_ff)
            2'd0: stlv_ff <= POS_W'(hdr_size(dsum_ff)) + dsum_ff;
            2'd1: main_ff <= POS_W'(18) + POS_W'(hdr_size(stlv_ff)) + stlv_ff;
            2'd2: total_ff <= mode_ff ? stlv_ff : POS_W'(hdr_size(main_ff)) + main_ff;
            default: begin
               r_ff   <= (pos_ff >= total_ff) ? '0 : pos_ff;
               seg_ff <= mode_ff ? SG_SEQ_HDR : SG_OUTER_HDR;
               ci_ff  <= '0;
               off_ff <= '0;
            end
         endcase
      end
      if (cmd.walk) begin
         if (hit) begin
            res_byte_ff <= seg_byte;
         end else begin
            r_ff <= r_ff - seglen;
            case (seg_ff)
               SG_OUTER_HDR: seg_ff <= SG_VER0;
               SG_VER0:      seg_ff <= SG_ALG;
               SG_ALG:       seg_ff <= SG_OCT_HDR;
               SG_OCT_HDR:   seg_ff <= SG_SEQ_HDR;
               SG_SEQ_HDR:   seg_ff <= SG_VER;
               SG_VER:       seg_ff <= SG_INT_HDR;
               SG_INT_HDR:   seg_ff <= SG_INT_BODY;
               SG_INT_BODY: begin
                  seg_ff <= SG_INT_HDR;
                  ci_ff  <= ci_ff + 3'd1;
                  off_ff <= off_ff + POS_W'(len_ff[idx]);
               end
               default: seg_ff <= SG_INT_HDR;
            endcase
         end
      end
      if (cmd.capture) begin
         res_byte_ff <= ram_q;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff   <= res_byte_ff;
         rsp_last_ff   <= (res_status_ff == STAT_OK) && pos_end;
         rsp_status_ff <= res_status_ff;
      end
   end

   // status back to the controller
   assign sts.bad      = err_ff || (next_ff < 4'd8);
   assign sts.sum_done = (ci_ff == 3'd7);
   assign sts.tot_done = (tcnt_ff == 2'd3);
   assign sts.hit      = hit;
   assign sts.mem      = mem_rd;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;
endmodule

[sim/der_rsa_private_key_encoder_unit_test.sv]
// self-checking testbench for the der rsa private key encoder unit
module der_rsa_private_key_encoder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dke_pkg::*;

   localparam int STORE_BYTES = BUFFER_BYTES_DEF;

   // one request as queued for the driver
   typedef struct packed {
      logic [0:0] func;
      logic [2:0] component;
      logic [7:0] value_byte;
      logic       byte_last;
   } key_req_type;

   // one expected response
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] status;
   } der_octet_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   der_rsa_private_key_encoder_unit u_dut (.*);

   // free-running clock
   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the key store and encoder state
   logic [7:0]  key_bytes [STORE_BYTES];
   int unsigned int_bytes [8];
   bit          int_pad [8];
   int unsigned next_int;
   int unsigned bytes_stored;
   bit          in_magnitude;
   bit          sticky_error;
   int unsigned der_pos;
   bit          mode_pkcs1;
   logic [7:0]  version_val;

   key_req_type    pending_reqs [$];
   der_octet_type  expected_octets [$];
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             hold_off_cycles = 0;
   bit             accepted;

   function automatic int unsigned len_octets(int unsigned v);
      int unsigned n;
      n = 0;
      while (v != 0) begin
         n++;
         v >>= 8;
      end
      return n;
   endfunction

   function automatic int unsigned tlv_head(int unsigned len);
      return (len <= 127) ? 2 : 2 + len_octets(len);
   endfunction

   function automatic logic [7:0] head_octet(logic [7:0] tag, int unsigned len,
                                            int unsigned k);
      int unsigned n;
      if (k == 0) return tag;
      if (len <= 127) return len[7:0];
      n = len_octets(len);
      if (k == 1) return 8'h80 | n[7:0];
      return 8'((len >> (8 * (n - (k - 1)))) & 'hFF);
   endfunction

   function automatic int unsigned int_tlv_len(int unsigned i);
      return int_bytes[i] + int_pad[i];
   endfunction

   function automatic int unsigned version_len();
      return (version_val >= 8'h80) ? 4 : 3;
   endfunction

   function automatic int unsigned key_body_len();
      int unsigned s;
      s = version_len();
      for (int i = 0; i < 8; i++) s += tlv_head(int_tlv_len(i)) + int_tlv_len(i);
      return s;
   endfunction

   function automatic int unsigned key_seq_len();
      return tlv_head(key_body_len()) + key_body_len();
   endfunction

   function automatic int unsigned wrapper_body_len();
      return 18 + tlv_head(key_seq_len()) + key_seq_len();
   endfunction

   function automatic int unsigned der_total_len();
      if (mode_pkcs1) return key_seq_len();
      return tlv_head(wrapper_body_len()) + wrapper_body_len();
   endfunction

   function automatic logic [7:0] rsa_alg_octet(int unsigned k);
      logic [7:0] oid [15];
      oid = '{8'h30, 8'h0D, 8'h06, 8'h09, 8'h2A, 8'h86, 8'h48, 8'h86,
              8'hF7, 8'h0D, 8'h01, 8'h01, 8'h01, 8'h05, 8'h00};
      return oid[k];
   endfunction

   // octet at position r of the full encoding
   function automatic logic [7:0] der_octet_at(int unsigned r);
      int unsigned d, hs, il, off, vt, idx;
      if (!mode_pkcs1) begin
         d = wrapper_body_len();
         hs = tlv_head(d);
         if (r < hs) return head_octet(TAG_SEQUENCE, d, r);
         r -= hs;
         if (r < 3) return (r == 0) ? TAG_INTEGER : (r == 1) ? 8'h01 : 8'h00;
         r -= 3;
         if (r < 15) return rsa_alg_octet(r);
         r -= 15;
         d = key_seq_len();
         hs = tlv_head(d);
         if (r < hs) return head_octet(TAG_OCTETS, d, r);
         r -= hs;
      end
      d = key_body_len();
      hs = tlv_head(d);
      if (r < hs) return head_octet(TAG_SEQUENCE, d, r);
      r -= hs;
      vt = version_len();
      if (r < vt) begin
         if (r == 0) return TAG_INTEGER;
         if (r == 1) return 8'(vt - 2);
         if (r == vt - 1) return version_val;
         return 8'h00;
      end
      r -= vt;
      off = 0;
      for (int i = 0; i < 8; i++) begin
         il = int_tlv_len(i);
         hs = tlv_head(il);
         if (r < hs) return head_octet(TAG_INTEGER, il, r);
         r -= hs;
         if (r < il) begin
            if (int_pad[i] && r == 0) return 8'h00;
            idx = off + r - int_pad[i];
            return key_bytes[idx];
         end
         r -= il;
         off += int_bytes[i];
      end
      return 8'h00;
   endfunction

   // advance the shadow state for one accepted request
   task automatic encode_request(input key_req_type rq);
      der_octet_type o;
      int unsigned tot;
      if (rq.func == FUNC_LOAD) begin
         if (next_int >= 8 || rq.component != next_int) begin
            sticky_error = 1;
            return;
         end
         if (in_magnitude || rq.value_byte != 0) begin
            if (bytes_stored >= STORE_BYTES) begin
               sticky_error = 1;
               return;
            end
            if (!in_magnitude) int_pad[rq.component] = rq.value_byte[7];
            in_magnitude = 1;
            key_bytes[bytes_stored] = rq.value_byte;
            bytes_stored++;
            int_bytes[rq.component]++;
         end
         if (rq.byte_last) begin
            if (int_bytes[rq.component] == 0) int_pad[rq.component] = 1;
            in_magnitude = 0;
            next_int++;
         end
         return;
      end
      if (sticky_error || next_int < 8) begin
         o.out_byte = 8'h00;
         o.out_last = 1'b0;
         o.status = sticky_error ? STAT_ERROR : STAT_PENDING;
      end else begin
         tot = der_total_len();
         if (der_pos >= tot) der_pos = 0;
         o.out_byte = der_octet_at(der_pos);
         o.out_last = (der_pos + 1 == tot);
         o.status = STAT_OK;
         der_pos = (der_pos + 1 == tot) ? 0 : der_pos + 1;
      end
      expected_octets.push_back(o);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || accepted) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            key_req_type rq;
            rq = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= rq.func;
            req_tdata  <= {5'b0, rq.value_byte, rq.component};
            req_tlast  <= rq.byte_last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall, with an optional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // request acceptance and response checking
   always @(posedge clock) begin
      accepted = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            key_req_type rq;
            rq.func = req_tuser;
            rq.component = req_tdata[2:0];
            rq.value_byte = req_tdata[10:3];
            rq.byte_last = req_tlast;
            encode_request(rq);
            accepted = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_octets.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: byte %h last %b status %0d",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               der_octet_type e;
               e = expected_octets.pop_front();
               if (e.out_byte !== rsp_tdata || e.out_last !== rsp_tlast ||
                   e.status !== rsp_tuser) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp byte %h last %b status %0d, got %h %b %0d",
                              e.out_byte, e.out_last, e.status,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
      end
   end

   task automatic queue_req(input logic [0:0] f, input int c, input logic [7:0] v,
                            input bit l);
      key_req_type rq;
      rq.func = f;
      rq.component = c[2:0];
      rq.value_byte = v;
      rq.byte_last = l;
      pending_reqs.push_back(rq);
   endtask

   task automatic queue_pulls(input int n);
      for (int i = 0; i < n; i++)
         queue_req(FUNC_PULL, int'($urandom_range(7)), 8'($urandom), 1'($urandom));
   endtask

   // one integer of n bytes, with an optional forced first byte
   task automatic queue_integer(input int c, input int n, input int lead);
      logic [7:0] v;
      for (int i = 0; i < n; i++) begin
         v = 8'($urandom);
         if (i == 0 && lead >= 0) v = lead[7:0];
         queue_req(FUNC_LOAD, c, v, i == n - 1);
      end
   endtask

   // wait until the queues drain and the block settles
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_octets.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PKCS1_MODE) mode_pkcs1 = val[0];
      else version_val = val;
   endtask

   task automatic clear_shadow();
      for (int i = 0; i < 8; i++) begin
         int_bytes[i] = 0;
         int_pad[i] = 0;
      end
      next_int = 0;
      bytes_stored = 0;
      in_magnitude = 0;
      sticky_error = 0;
      der_pos = 0;
      mode_pkcs1 = 0;
      version_val = 0;
   endtask

   // stimulus
   initial begin
      clear_shadow();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: early pull, zero integer, padded integer, length of 127
      queue_pulls(2);
      queue_integer(0, 127, 8'h12);
      queue_integer(1, 3, 8'h01);
      queue_req(FUNC_LOAD, 2, 8'h00, 0);
      queue_req(FUNC_LOAD, 2, 8'h00, 1);
      queue_integer(3, 1, 8'hFF);
      queue_req(FUNC_LOAD, 4, 8'h00, 0);
      queue_integer(4, 2, 8'h7F);
      queue_integer(5, 12, 8'hC3);
      queue_integer(6, 3, 8'h80);
      queue_integer(7, 1, 8'h00);
      drain();
      write_reg(CSR_KEY_VERSION, 8'hFF);
      queue_pulls(20);
      drain();
      write_reg(CSR_PKCS1_MODE, 8'h01);
      write_reg(CSR_KEY_VERSION, 8'h00);
      queue_pulls(20);
      // long hold-off while pulls keep coming
      drain();
      hold_off_cycles = 400;
      queue_pulls(30);
      drain();

      // random: pulls under each idling phase and setting
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 68 : 0;
         recv_stall_pct = (ph >= 2) ? 68 : 0;
         if (ph == 3) begin
            send_idle_pct = 12;
            recv_stall_pct = 12;
         end
         write_reg(CSR_PKCS1_MODE, {7'b0, ph[0]});
         write_reg(CSR_KEY_VERSION, (ph == 2) ? 8'h80 : 8'($urandom));
         queue_pulls(25);
         drain();
         write_reg(CSR_PKCS1_MODE, 8'($urandom));
         write_reg(CSR_KEY_VERSION, 8'($urandom));
         queue_pulls(25);
         drain();
      end

      // out-of-order load makes the error sticky
      queue_req(FUNC_LOAD, 3, 8'h55, 1);
      queue_pulls(8);
      drain();

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/dke_pkg.sv
hw/rtl/dke_ram.sv
hw/rtl/dke_ctrl.sv
hw/rtl/dke_dpath.sv
hw/rtl/der_rsa_private_key_encoder_unit.sv
sim/der_rsa_private_key_encoder_unit_test.sv
